FILE: rtl/kcl_pkg.sv
`default_nettype none

package kcl_pkg;

    localparam int unsigned SCAN_W   = 16;
    localparam int unsigned CHAR_W   = 7;
    localparam int unsigned TICK_W   = 10;
    localparam int unsigned HALF_W   = 8;
    localparam int unsigned HALVES_W = 6;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 10;

    // reset values of the settings
    localparam logic [CHAR_W-1:0]   RST_FIRST_KEY  = 7'd48;  // '0'
    localparam logic [CHAR_W-1:0]   RST_SECOND_KEY = 7'd51;  // '3'
    localparam logic [TICK_W-1:0]   RST_SUCC_TICKS = 10'd40;
    localparam logic [HALF_W-1:0]   RST_HALF_TICKS = 8'd5;
    localparam logic [HALVES_W-1:0] RST_HALVES     = 6'd8;

    localparam logic OP_SCAN = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FIRST_KEY  = 3'd0,
        CFG_SECOND_KEY = 3'd1,
        CFG_SUCC_TICKS = 3'd2,
        CFG_HALF_TICKS = 3'd3,
        CFG_HALVES     = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        VD_NONE = 2'd0,
        VD_PASS = 2'd1,
        VD_FAIL = 2'd2
    } t_verdict;

    typedef enum logic [3:0] {
        PH_FIRST   = 4'b0001,
        PH_SECOND  = 4'b0010,
        PH_SUCCESS = 4'b0100,
        PH_BLINK   = 4'b1000
    } t_phase;

    typedef struct packed {
        logic [CHAR_W-1:0]   first_key;
        logic [CHAR_W-1:0]   second_key;
        logic [TICK_W-1:0]   succ_ticks;
        logic [HALF_W-1:0]   half_ticks;
        logic [HALVES_W-1:0] halves;
    } t_cfg;

    typedef struct packed {
        logic              hit;
        logic [CHAR_W-1:0] code;
    } t_key_info;

    typedef struct packed {
        logic              lamp_on;
        logic              key_valid;
        logic [CHAR_W-1:0] key_char;
        t_verdict          verdict;
    } t_result;

    // keypad legend by bit: "123A" "456B" "789C" "*0#D"
    localparam logic [CHAR_W-1:0] KEY_ASCII [SCAN_W] = '{
        7'h31, 7'h32, 7'h33, 7'h41,
        7'h34, 7'h35, 7'h36, 7'h42,
        7'h37, 7'h38, 7'h39, 7'h43,
        7'h2A, 7'h30, 7'h23, 7'h44
    };

endpackage

`default_nettype wire

FILE: rtl/keypad_two_key_code_lock.sv
`default_nettype none

// channel   valid     stall     payload
// request   i_valid   o_stall   i_operation, i_first_scan, i_second_scan
// result    o_valid   i_stall   o_lamp_on, o_key_valid, o_key_char, o_verdict
// settings  i_cfg_we  -         i_cfg_index, i_cfg_data
//
// One request per cycle while i_stall does not hold the result register; a request passes
// the request register, then the lock update feeds the result register.
// Synchronous active-low reset: lock waits for a first key, lamp off,
// settings back to defaults.
// o_stall rises only while the result register is full and i_stall holds it.

module keypad_two_key_code_lock
    import kcl_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic                  i_operation,
    input  wire logic [SCAN_W-1:0]     i_first_scan,
    input  wire logic [SCAN_W-1:0]     i_second_scan,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic                       o_lamp_on,
    output logic                       o_key_valid,
    output logic [CHAR_W-1:0]          o_key_char,
    output logic [1:0]                 o_verdict,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic              r_in_valid;
    logic              r_op;
    logic [SCAN_W-1:0] r_scan_a;
    logic [SCAN_W-1:0] r_scan_b;
    logic              r_out_valid;
    t_result           r_res;
    t_result           w_res;
    t_cfg              r_cfg;
    logic              w_adv;

    assign w_adv   = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && !w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.first_key  <= RST_FIRST_KEY;
            r_cfg.second_key <= RST_SECOND_KEY;
            r_cfg.succ_ticks <= RST_SUCC_TICKS;
            r_cfg.half_ticks <= RST_HALF_TICKS;
            r_cfg.halves     <= RST_HALVES;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FIRST_KEY:  r_cfg.first_key  <= i_cfg_data[CHAR_W-1:0];
                CFG_SECOND_KEY: r_cfg.second_key <= i_cfg_data[CHAR_W-1:0];
                CFG_SUCC_TICKS: r_cfg.succ_ticks <= i_cfg_data[TICK_W-1:0];
                CFG_HALF_TICKS: r_cfg.half_ticks <= i_cfg_data[HALF_W-1:0];
                CFG_HALVES:     r_cfg.halves     <= i_cfg_data[HALVES_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_op     <= i_operation;
            r_scan_a <= i_first_scan;
            r_scan_b <= i_second_scan;
        end
    end

    kcl_lock_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (w_adv),
        .i_operation   (r_op),
        .i_first_scan  (r_scan_a),
        .i_second_scan (r_scan_b),
        .i_cfg         (r_cfg),
        .o_result      (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_res <= w_res;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_lamp_on   = r_res.lamp_on;
    assign o_key_valid = r_res.key_valid;
    assign o_key_char  = r_res.key_char;
    assign o_verdict   = r_res.verdict;

endmodule

`default_nettype wire

FILE: rtl/kcl_key_enc.sv
`default_nettype none

module kcl_key_enc
    import kcl_pkg::*;
(
    input  wire logic [SCAN_W-1:0] i_deb,
    input  wire logic [SCAN_W-1:0] i_last,
    output t_key_info              o_key
);

    logic [SCAN_W-1:0] w_fresh;

    assign w_fresh = i_deb & ~i_last;

    // later hits override: top row wins, leftmost column within a row
    always_comb begin
        o_key.hit  = |w_fresh;
        o_key.code = '0;
        for (int row = 0; row < 4; row++) begin
            for (int col = 3; col >= 0; col--) begin
                if (w_fresh[row*4 + col]) begin
                    o_key.code = KEY_ASCII[row*4 + col];
                end
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/kcl_lock_ctrl.sv
`default_nettype none

module kcl_lock_ctrl
    import kcl_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_step,
    input  wire logic              i_operation,
    input  wire logic [SCAN_W-1:0] i_first_scan,
    input  wire logic [SCAN_W-1:0] i_second_scan,
    input  wire t_cfg              i_cfg,
    output t_result                o_result
);

    t_phase              r_phase,  n_phase;
    logic [SCAN_W-1:0]   r_last,   n_last;
    logic                r_ok,     n_ok;
    logic [TICK_W-1:0]   r_tick,   n_tick;
    logic [HALVES_W-1:0] r_halves, n_halves;
    logic                r_lamp,   n_lamp;

    logic [SCAN_W-1:0] w_deb;
    t_key_info         w_key;

    assign w_deb = i_first_scan & i_second_scan;

    kcl_key_enc u_enc (
        .i_deb  (w_deb),
        .i_last (r_last),
        .o_key  (w_key)
    );

    always_comb begin
        n_phase  = r_phase;
        n_last   = r_last;
        n_ok     = r_ok;
        n_tick   = r_tick;
        n_halves = r_halves;
        n_lamp   = r_lamp;
        o_result.key_valid = 1'b0;
        o_result.key_char  = '0;
        o_result.verdict   = VD_NONE;

        unique case (r_phase)
            PH_FIRST, PH_SECOND: begin
                if (i_operation == OP_SCAN) begin
                    n_last = w_deb;
                    if (w_key.hit) begin
                        o_result.key_valid = 1'b1;
                        o_result.key_char  = w_key.code;
                        if (r_phase == PH_FIRST) begin
                            n_ok    = (w_key.code == i_cfg.first_key);
                            n_phase = PH_SECOND;
                        end else begin
                            n_tick   = '0;
                            n_halves = '0;
                            n_lamp   = 1'b1;
                            if (r_ok && (w_key.code == i_cfg.second_key)) begin
                                o_result.verdict = VD_PASS;
                                n_phase          = PH_SUCCESS;
                            end else begin
                                o_result.verdict = VD_FAIL;
                                n_phase          = PH_BLINK;
                            end
                        end
                    end
                end
            end
            PH_SUCCESS: begin
                if (i_operation == OP_TICK) begin
                    n_tick = r_tick + 1'b1;
                    if (n_tick >= i_cfg.succ_ticks) begin
                        n_phase = PH_FIRST;
                        n_lamp  = 1'b0;
                        n_last  = '0;
                        n_ok    = 1'b0;
                        n_tick  = '0;
                        n_halves = '0;
                    end
                end
            end
            PH_BLINK: begin
                if (i_operation == OP_TICK) begin
                    n_tick = r_tick + 1'b1;
                    if (n_tick >= TICK_W'(i_cfg.half_ticks)) begin
                        n_tick   = '0;
                        n_halves = r_halves + 1'b1;
                        n_lamp   = ~r_lamp;
                        if (n_halves >= i_cfg.halves) begin
                            n_phase  = PH_FIRST;
                            n_lamp   = 1'b0;
                            n_last   = '0;
                            n_ok     = 1'b0;
                            n_halves = '0;
                        end
                    end
                end
            end
            default: begin
                n_phase = PH_FIRST;
            end
        endcase

        o_result.lamp_on = n_lamp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_FIRST;
            r_last   <= '0;
            r_ok     <= 1'b0;
            r_tick   <= '0;
            r_halves <= '0;
            r_lamp   <= 1'b0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_last   <= n_last;
            r_ok     <= n_ok;
            r_tick   <= n_tick;
            r_halves <= n_halves;
            r_lamp   <= n_lamp;
        end
    end

    // lamp only shows during a display
    a_lamp_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_FIRST || r_phase == PH_SECOND) |-> !r_lamp)
        else $error("lamp lit while entering a code");

    // fresh attempt starts with clean edge memory
    a_first_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_FIRST) |-> (r_last == '0 && !r_ok))
        else $error("stale key memory in first phase");

    // a verdict always starts a display with the lamp on
    a_verdict_disp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_result.verdict != VD_NONE) |=>
            ((r_phase == PH_SUCCESS || r_phase == PH_BLINK) && r_lamp))
        else $error("verdict without display");

endmodule

`default_nettype wire

FILE: tb/tb_keypad_two_key_code_lock.sv
`default_nettype none

module tb_keypad_two_key_code_lock;
    import kcl_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD = 12;
    localparam int HOLD_CYCLES = 64;
    localparam int ITEMS_PER_MODE = 110;
    localparam longint TIMEOUT_NS = 64'd6_000_000;
    localparam string KEY_LEGEND = "123A456B789C*0#D";

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    logic                  i_operation = OP_SCAN;
    logic [SCAN_W-1:0]     i_first_scan = '0;
    logic [SCAN_W-1:0]     i_second_scan = '0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic                  o_lamp_on;
    logic                  o_key_valid;
    logic [CHAR_W-1:0]     o_key_char;
    logic [1:0]            o_verdict;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // lock model state
    t_cfg              lock_cfg;
    t_phase            lock_ph;
    logic [SCAN_W-1:0] held_keys;
    logic              code_ok;
    logic [TICK_W-1:0] tick_cnt;
    logic [HALVES_W-1:0] halves_cnt;
    logic              lamp;

    t_result result_q[$];

    int error_cnt = 0;
    int sent_cnt = 0;
    int checked_cnt = 0;
    int live_cnt = 0;
    int pass_cnt = 0;
    int fail_cnt = 0;
    int cfg_cnt = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_gen = 0;
    int hold_seen = 0;
    int hold_left = 0;

    keypad_two_key_code_lock DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_operation   (i_operation),
        .i_first_scan  (i_first_scan),
        .i_second_scan (i_second_scan),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_lamp_on     (o_lamp_on),
        .o_key_valid   (o_key_valid),
        .o_key_char    (o_key_char),
        .o_verdict     (o_verdict),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic t_cfg make_cfg(logic [CHAR_W-1:0] k1, logic [CHAR_W-1:0] k2,
                                      logic [TICK_W-1:0] succ, logic [HALF_W-1:0] half,
                                      logic [HALVES_W-1:0] halves);
        t_cfg c;
        c.first_key  = k1;
        c.second_key = k2;
        c.succ_ticks = succ;
        c.half_ticks = half;
        c.halves     = halves;
        return c;
    endfunction

    function automatic logic [CHAR_W-1:0] rand_key();
        return CHAR_W'(KEY_LEGEND[$urandom_range(SCAN_W - 1)]);
    endfunction

    function automatic logic [SCAN_W-1:0] key_mask(logic [CHAR_W-1:0] ch);
        for (int i = 0; i < SCAN_W; i++)
            if (CHAR_W'(KEY_LEGEND[i]) == ch) return SCAN_W'(1) << i;
        return '0;
    endfunction

    function automatic void clear_display();
        lamp       = 1'b0;
        lock_ph    = PH_FIRST;
        held_keys  = '0;
        code_ok    = 1'b0;
        tick_cnt   = '0;
        halves_cnt = '0;
    endfunction

    function automatic t_result lock_step(logic op, logic [SCAN_W-1:0] a,
                                          logic [SCAN_W-1:0] b);
        t_result r;
        logic [SCAN_W-1:0] deb;
        logic [SCAN_W-1:0] fresh;
        r = '0;
        if (op == OP_SCAN) begin
            if (lock_ph == PH_FIRST || lock_ph == PH_SECOND) begin
                live_cnt++;
                deb = a & b;
                fresh = deb & ~held_keys;
                held_keys = deb;
                if (fresh != '0) begin
                    r.key_valid = 1'b1;
                    // top row first, then left to right
                    for (int row = 3; row >= 0; row--)
                        for (int col = 0; col < 4; col++)
                            if (fresh[row * 4 + col] && r.key_char == '0)
                                r.key_char = CHAR_W'(KEY_LEGEND[row * 4 + col]);
                    if (lock_ph == PH_FIRST) begin
                        code_ok = (r.key_char == lock_cfg.first_key);
                        lock_ph = PH_SECOND;
                    end else begin
                        tick_cnt = '0;
                        halves_cnt = '0;
                        lamp = 1'b1;
                        if (code_ok && r.key_char == lock_cfg.second_key) begin
                            r.verdict = VD_PASS;
                            lock_ph = PH_SUCCESS;
                            pass_cnt++;
                        end else begin
                            r.verdict = VD_FAIL;
                            lock_ph = PH_BLINK;
                            fail_cnt++;
                        end
                    end
                end
            end
        end else if (lock_ph == PH_SUCCESS) begin
            live_cnt++;
            tick_cnt = tick_cnt + 1'b1;
            if (tick_cnt >= lock_cfg.succ_ticks) clear_display();
        end else if (lock_ph == PH_BLINK) begin
            live_cnt++;
            tick_cnt = tick_cnt + 1'b1;
            if (tick_cnt >= TICK_W'(lock_cfg.half_ticks)) begin
                tick_cnt = '0;
                halves_cnt = halves_cnt + 1'b1;
                lamp = ~lamp;
                // odd half counts still end dark
                if (halves_cnt >= lock_cfg.halves) clear_display();
            end
        end
        r.lamp_on = lamp;
        return r;
    endfunction

    task automatic set_idling(int send_pct, int recv_pct);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    // valid is left high on return; wait_drain or the next request decides
    task automatic send_request(logic op, logic [SCAN_W-1:0] a, logic [SCAN_W-1:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_operation <= op;
        i_first_scan <= a;
        i_second_scan <= b;
        @(posedge i_clk);
        while (o_stall !== 1'b0) @(posedge i_clk);
        result_q.push_back(lock_step(op, a, b));
        sent_cnt++;
    endtask

    task automatic wait_drain();
        i_valid <= 1'b0;
        while (result_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val, int w);
        logic [CFG_DATA_W-1:0] junk;
        junk = CFG_DATA_W'($urandom);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= (junk << w) | val;
        @(posedge i_clk);
    endtask

    // unused bits of the data word and the spare indexes get random junk
    task automatic set_config(t_cfg c);
        write_reg(CFG_FIRST_KEY, CFG_DATA_W'(c.first_key), CHAR_W);
        write_reg(CFG_SECOND_KEY, CFG_DATA_W'(c.second_key), CHAR_W);
        write_reg(CFG_SUCC_TICKS, CFG_DATA_W'(c.succ_ticks), TICK_W);
        write_reg(CFG_HALF_TICKS, CFG_DATA_W'(c.half_ticks), HALF_W);
        write_reg(CFG_HALVES, CFG_DATA_W'(c.halves), HALVES_W);
        for (int k = int'(CFG_HALVES) + 1; k < 2 ** CFG_IDX_W; k++)
            write_reg(CFG_IDX_W'(k), '0, 0);
        i_cfg_we <= 1'b0;
        lock_cfg = c;
        cfg_cnt++;
    endtask

    task automatic press_key(logic [CHAR_W-1:0] ch);
        logic [SCAN_W-1:0] held;
        logic [SCAN_W-1:0] bounce;
        held = key_mask(ch);
        if ($urandom_range(4) == 0) held |= SCAN_W'($urandom);
        bounce = SCAN_W'($urandom);
        send_request(OP_SCAN, held | bounce, held | (SCAN_W'($urandom) & ~bounce));
    endtask

    task automatic release_keys();
        logic [SCAN_W-1:0] bounce;
        bounce = SCAN_W'($urandom);
        send_request(OP_SCAN, bounce, SCAN_W'($urandom) & ~bounce);
    endtask

    task automatic play_out_display();
        while (lock_ph == PH_SUCCESS || lock_ph == PH_BLINK) begin
            if ($urandom_range(9) == 0)
                send_request(OP_SCAN, SCAN_W'($urandom), SCAN_W'($urandom));
            else
                send_request(OP_TICK, SCAN_W'($urandom), SCAN_W'($urandom));
        end
    endtask

    task automatic try_code(logic [CHAR_W-1:0] k1, logic [CHAR_W-1:0] k2);
        release_keys();
        press_key(k1);
        if ($urandom_range(1)) release_keys();
        press_key(k2);
        play_out_display();
    endtask

    task automatic test_reset_values();
        try_code("0", "3");
        try_code("3", "0");
    endtask

    task automatic test_directed();
        wait_drain();
        set_config(make_cfg("#", "A", 2, 2, 3));
        send_request(OP_TICK, '0, '0);              // tick while waiting
        send_request(OP_SCAN, '1, '1);              // whole pad: '*' wins
        send_request(OP_SCAN, '1, '0);              // bounce ANDs to nothing
        send_request(OP_SCAN, '0, '1);
        send_request(OP_SCAN, 16'h000F, 16'h000F);  // '1' ends a wrong code
        send_request(OP_SCAN, 16'h2000, 16'h2000);  // ignored during blink
        play_out_display();
        send_request(OP_SCAN, 16'h4000, 16'h4000);  // '#'
        send_request(OP_SCAN, 16'h4000, 16'h4000);  // still held
        send_request(OP_SCAN, 16'h4008, 16'h4008);  // only 'A' is fresh
        play_out_display();
        send_request(OP_SCAN, 16'h0F00, 16'h0F00);  // '7' leads its row
        send_request(OP_SCAN, 16'h0FF0, 16'h0FF0);  // fresh row 1 gives '4'
        play_out_display();
    endtask

    task automatic test_register_extremes();
        wait_drain();
        set_config(make_cfg("0", "3", 0, 0, 0));    // zero timing acts like one
        try_code("0", "3");
        try_code("1", "3");
        wait_drain();
        set_config(make_cfg("0", "3", 1023, 255, 1));
        try_code("0", "0");
        wait_drain();
        set_config(make_cfg("0", "3", 1, 1, 63));
        try_code("3", "0");
        wait_drain();
        set_config(make_cfg(7'h7F, 7'h00, 1, 1, 2));
        try_code("0", "3");
        try_code("D", "*");
        wait_drain();
        set_config(make_cfg("D", "*", 2, 1, 3));
        try_code("D", "*");
        try_code("D", "#");
    endtask

    task automatic test_backpressure();
        wait_drain();
        set_idling(0, 0);
        hold_gen++;
        repeat (5) try_code(lock_cfg.first_key, lock_cfg.second_key);
        // wait for every outstanding result before going on
        wait_drain();
    endtask

    task automatic test_random();
        int target;
        logic [CHAR_W-1:0] k1;
        logic [CHAR_W-1:0] k2;
        for (int mode = 0; mode < 3; mode++) begin
            wait_drain();
            case (mode)
                0: set_idling(24, 88);
                1: set_idling(88, 24);
                default: set_idling(0, 0);
            endcase
            set_config(make_cfg(rand_key(), rand_key(), TICK_W'($urandom_range(1, 8)),
                                HALF_W'($urandom_range(1, 4)),
                                HALVES_W'($urandom_range(1, 7))));
            target = live_cnt + ITEMS_PER_MODE;
            while (live_cnt < target) begin
                if ($urandom_range(3) != 0) begin
                    k1 = $urandom_range(1) ? lock_cfg.first_key : rand_key();
                    k2 = $urandom_range(1) ? lock_cfg.second_key : rand_key();
                    try_code(k1, k2);
                end else begin
                    send_request(1'($urandom), SCAN_W'($urandom), SCAN_W'($urandom));
                end
            end
        end
    endtask

    task automatic check_field(string what, logic [CHAR_W-1:0] want, logic [CHAR_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
            error_cnt++;
        end
    endtask

    always @(posedge i_clk) begin
        if (hold_gen != hold_seen) begin
            hold_seen = hold_gen;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid === 1'b1 && i_stall == 1'b0) begin
            if (result_q.size() == 0) begin
                $display("%0t: unexpected result, lamp %0b key %0b char %0h verdict %0d",
                         $time, o_lamp_on, o_key_valid, o_key_char, o_verdict);
                error_cnt++;
            end else begin
                want = result_q.pop_front();
                check_field("lamp_on", CHAR_W'(want.lamp_on), CHAR_W'(o_lamp_on));
                check_field("key_valid", CHAR_W'(want.key_valid), CHAR_W'(o_key_valid));
                check_field("key_char", want.key_char, o_key_char);
                check_field("verdict", CHAR_W'(want.verdict), CHAR_W'(o_verdict));
                checked_cnt++;
            end
        end
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Timeout with %0d results outstanding", result_q.size());
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        lock_cfg = make_cfg(RST_FIRST_KEY, RST_SECOND_KEY, RST_SUCC_TICKS,
                            RST_HALF_TICKS, RST_HALVES);
        clear_display();
        set_idling(24, 88);
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_values();
        test_directed();
        test_register_extremes();
        test_backpressure();
        test_random();
        wait_drain();

        $display("Checked %0d of %0d requests over %0d register settings,", checked_cnt,
                 sent_cnt, cfg_cnt);
        $display("with %0d codes accepted and %0d rejected under mixed flow control.",
                 pass_cnt, fail_cnt);
        if (error_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: files.f
rtl/kcl_pkg.sv
rtl/kcl_key_enc.sv
rtl/kcl_lock_ctrl.sv
rtl/keypad_two_key_code_lock.sv
tb/tb_keypad_two_key_code_lock.sv
